FILE: src/bpc_pkg.sv
// Shared types, register indexes and constants for the barometric compensation block.
// No dependencies; imported by baro_pressure_temp_compensation, bpc_checker and the testbench.
package bpc_pkg;

  // Input request payload
  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } bpc_in_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] pressure_pa;
    logic signed [31:0] temp_centi;
  } bpc_out_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CAL_LOW  = 2'd0,
    REG_CAL_MID  = 2'd1,
    REG_CAL_HIGH = 2'd2,
    REG_FORMULA  = 2'd3
  } bpc_reg_t;

  localparam int unsigned NumStages = 15;

  // Offsets and bases are signed so that the datapath shifts stay arithmetic.
  localparam logic [7:0]         FormulaReset = 8'd1;
  localparam logic signed [31:0] RawOffset    = 32'sd8388608;
  localparam logic signed [31:0] TempBase     = 32'sd81920000;
  localparam logic signed [31:0] CfBase       = 32'sd2097152;
  localparam logic signed [31:0] PressBase    = 32'sd99880;
  localparam logic signed [31:0] C2Offset     = 32'sd256;

  // Second-revision formula constants
  localparam logic [31:0] Rev2K1 = 32'd4459;
  localparam logic [31:0] Rev2K5 = 32'd4443;
  localparam logic [31:0] Rev2K4 = 32'd120586;
  localparam logic [31:0] Rev2K8 = 32'd7180;
  localparam logic [31:0] Rev2K7 = 32'd166426;

  // First-revision formula constants
  localparam logic [31:0] Rev1K1 = 32'd4418;
  localparam logic [31:0] Rev1K5 = 32'd0;
  localparam logic [31:0] Rev1K4 = 32'd211288;
  localparam logic [31:0] Rev1K8 = 32'd7209;
  localparam logic [31:0] Rev1K7 = 32'd285594;

endpackage

FILE: src/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Depends on bpc_pkg for payload types, register indexes and constants.

// One request (raw pressure and raw temperature) enters per cycle unless in_stall is high;
// throughput is one request per cycle while the receiver does not stall, set by a 15-stage
// pipeline with at most one 32x32 multiply on any path through a stage. Each stage
// holds its data while the stage after it is full and stalled, so bubbles collapse
// and the input stalls only when every stage is occupied. Coefficients are unpacked
// from the calibration words into registers in the cycle after a configuration write;
// write configuration only while the pipeline is empty. All arithmetic wraps at 32 bits.
module baro_pressure_temp_compensation
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  bpc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output bpc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Configuration registers
  logic [63:0] cal_low_r;
  logic [63:0] cal_mid_r;
  logic [31:0] cal_high_r;
  logic [7:0]  formula_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r  <= '0;
      cal_mid_r  <= '0;
      cal_high_r <= '0;
      formula_r  <= FormulaReset;
    end else if (cfg_we) begin
      case (bpc_reg_t'(cfg_index))
        REG_CAL_LOW:  cal_low_r  <= cfg_wdata;
        REG_CAL_MID:  cal_mid_r  <= cfg_wdata;
        REG_CAL_HIGH: cal_high_r <= cfg_wdata[31:0];
        REG_FORMULA:  formula_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Calibration word views
  logic [15:0] w0, w1, w2, w3, w4, w5, w6, w7, w8, w9;
  logic        rev2;
  assign w0 = cal_low_r[15:0];
  assign w1 = cal_low_r[31:16];
  assign w2 = cal_low_r[47:32];
  assign w3 = cal_low_r[63:48];
  assign w4 = cal_mid_r[15:0];
  assign w5 = cal_mid_r[31:16];
  assign w6 = cal_mid_r[47:32];
  assign w7 = cal_mid_r[63:48];
  assign w8 = cal_high_r[15:0];
  assign w9 = cal_high_r[31:16];
  assign rev2 = (formula_r[7:4] == 4'd1) || (formula_r[3:0] == 4'd1);

  // Coefficient unpacking, with the formula constants already folded in
  logic signed [31:0] c0s_nxt, kc1_nxt, kc2_nxt, c3_nxt, k4s_nxt, kc5_nxt, c6_nxt;
  logic signed [31:0] k7_nxt, kc8_nxt, c9_nxt, c10_nxt, c11_nxt, c12_nxt;
  logic signed [31:0] c0s_r, kc1_r, kc2_r, c3_r, k4s_r, kc5_r, c6_r;
  logic signed [31:0] k7_r, kc8_r, c9_r, c10_r, c11_r, c12_r;

  always_comb begin
    logic [31:0] c4, c7, c12;
    logic [31:0] k1, k5, k4, k8, k7;
    if (rev2) begin
      c4  = {14'd0, w3, w0[1:0]};
      c7  = {13'd0, w6, w5[2:0]};
      c12 = {27'd0, w0[3:2], w7[2:0]};
      k1 = Rev2K1; k5 = Rev2K5; k4 = Rev2K4; k8 = Rev2K8; k7 = Rev2K7;
    end else begin
      c4  = {15'd0, w3, w5[0]};
      c7  = {14'd0, w6, w0[3:2]};
      c12 = {27'd0, w5[2:1], w7[2:0]};
      k1 = Rev1K1; k5 = Rev1K5; k4 = Rev1K4; k8 = Rev1K8; k7 = Rev1K7;
    end
    c0s_nxt = {16'd0, w0[15:4], 4'd0};
    kc1_nxt = {21'd0, w1[15:8], w2[2:0]} + k1;
    kc2_nxt = {23'd0, w1[7:0], w4[0]} - C2Offset;
    c3_nxt  = {19'd0, w2[15:3]};
    k4s_nxt = (c4 + k4) << 4;
    kc5_nxt = {17'd0, w4[15:1]} - k5;
    c6_nxt  = {19'd0, w5[15:3]};
    k7_nxt  = c7 + k7;
    kc8_nxt = {19'd0, w7[15:3]} + k8;
    c9_nxt  = {18'd0, w8[15:2]};
    c10_nxt = {22'd0, w9[15:8], w8[1:0]};
    c11_nxt = {24'd0, w9[7:0]};
    c12_nxt = c12;
  end

  always_ff @(posedge clk) begin
    c0s_r <= c0s_nxt; kc1_r <= kc1_nxt; kc2_r <= kc2_nxt; c3_r <= c3_nxt;
    k4s_r <= k4s_nxt; kc5_r <= kc5_nxt; c6_r <= c6_nxt; k7_r <= k7_nxt;
    kc8_r <= kc8_nxt; c9_r <= c9_nxt; c10_r <= c10_nxt; c11_r <= c11_nxt;
    c12_r <= c12_nxt;
  end

  // Stage valid bits and per-stage advance enables
  logic [NumStages-1:0] v_r;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_r[NumStages-1] || !out_stall;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NumStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Datapath registers, named by stage
  logic signed [31:0] s0_dt_r, s0_up_r;
  logic signed [31:0] s1_ma_r, s1_mb_r, s1_mc_r, s1_dt_r, s1_up_r;
  logic signed [31:0] s2_x01_r, s2_tb_r, s2_tc_r, s2_dt_r, s2_up_r;
  logic signed [31:0] s3_x01_r, s3_x02_r, s3_x03_r, s3_up_r;
  logic signed [31:0] s4_rt_r, s4_dt2_r, s4_up_r;
  logic signed [31:0] s5_p11_r, s5_p12_r, s5_p21_r, s5_p22_r, s5_pc_r, s5_dt2_r;
  logic signed [31:0] s5_rt_r, s5_up_r;
  logic signed [31:0] s6_p11_r, s6_q12_r, s6_x21_r, s6_q22_r, s6_cf_r, s6_rt_r, s6_up_r;
  logic signed [31:0] s7_x13_r, s7_x23_r, s7_f10_r, s7_f11_r, s7_rt_r, s7_up_r;
  logic               s7_neg_r;
  logic signed [31:0] s8_x24_r, s8_x25m_r, s8_pp1_r, s8_f10_r, s8_f11_r, s8_rt_r;
  logic               s8_neg_r;
  logic signed [31:0] s9_x26_r, s9_pp1_r, s9_f10_r, s9_f11_r, s9_rt_r;
  logic signed [31:0] s10_pp2_r, s10_pp3m_r, s10_f10_r, s10_f11_r, s10_rt_r;
  logic signed [31:0] s11_pp4_r, s11_f10_r, s11_f11_r, s11_rt_r;
  logic signed [31:0] s12_y31_r, s12_y32_r, s12_pp4_r, s12_rt_r;
  logic signed [31:0] s13_x31_r, s13_x32_r, s13_pp4_r, s13_rt_r;
  logic signed [31:0] s14_rp_r, s14_rt_r;

  // Combinational helpers between stages
  logic signed [31:0] ut_ext, up_ext, s7_x22, s7_d, s9_sum, s12_pp3;
  assign ut_ext  = {8'd0, in_data.raw_temperature};
  assign up_ext  = {8'd0, in_data.raw_pressure};
  assign s7_x22  = s6_q22_r >>> 12;
  assign s7_d    = s7_x22 - s6_x21_r;
  assign s9_sum  = s8_neg_r ? (32'sd0 - s8_x24_r - (s8_x25m_r >>> 11))
                            : (s8_x24_r + (s8_x25m_r >>> 11));
  assign s12_pp3 = s10_pp3m_r >>> 11;

  always_ff @(posedge clk) begin
    // Temperature offset
    if (en[0]) begin
      s0_dt_r <= ((ut_ext - RawOffset) >>> 4) + c0s_r;
      s0_up_r <= up_ext;
    end
    // First products on dt
    if (en[1]) begin
      s1_ma_r <= kc1_r * s0_dt_r;
      s1_mb_r <= kc2_r * s0_dt_r;
      s1_mc_r <= c3_r * s0_dt_r;
      s1_dt_r <= s0_dt_r;
      s1_up_r <= s0_up_r;
    end
    // Second products on dt
    if (en[2]) begin
      s2_x01_r <= s1_ma_r >>> 1;
      s2_tb_r  <= (s1_mb_r >>> 14) * s1_dt_r;
      s2_tc_r  <= (s1_mc_r >>> 18) * s1_dt_r;
      s2_dt_r  <= s1_dt_r;
      s2_up_r  <= s1_up_r;
    end
    // Cubic temperature term
    if (en[3]) begin
      s3_x01_r <= s2_x01_r;
      s3_x02_r <= s2_tb_r >>> 4;
      s3_x03_r <= (s2_tc_r >>> 18) * s2_dt_r;
      s3_up_r  <= s2_up_r;
    end
    // Temperature result and scaled dt
    if (en[4]) begin
      s4_rt_r  <= (TempBase - s3_x01_r - s3_x02_r - s3_x03_r) >>> 15;
      s4_dt2_r <= (s3_x01_r + s3_x02_r + s3_x03_r) >>> 12;
      s4_up_r  <= s3_up_r;
    end
    // First products on dt2
    if (en[5]) begin
      s5_p11_r <= kc5_r * s4_dt2_r;
      s5_p12_r <= c6_r * s4_dt2_r;
      s5_p21_r <= kc8_r * s4_dt2_r;
      s5_p22_r <= c9_r * s4_dt2_r;
      s5_pc_r  <= c12_r * s4_dt2_r;
      s5_dt2_r <= s4_dt2_r;
      s5_rt_r  <= s4_rt_r;
      s5_up_r  <= s4_up_r;
    end
    // Second products on dt2 and correction factor
    if (en[6]) begin
      s6_p11_r <= s5_p11_r;
      s6_q12_r <= (s5_p12_r >>> 16) * s5_dt2_r;
      s6_x21_r <= s5_p21_r >>> 10;
      s6_q22_r <= (s5_p22_r >>> 17) * s5_dt2_r;
      s6_cf_r  <= (CfBase + s5_pc_r) >>> 3;
      s6_rt_r  <= s5_rt_r;
      s6_up_r  <= s5_up_r;
    end
    // Offset term, sensitivity magnitude and correction products
    if (en[7]) begin
      s7_x13_r <= ((s6_p11_r + (s6_q12_r >>> 2)) >>> 10) + k4s_r;
      s7_x23_r <= (s7_x22 >= s6_x21_r) ? s7_d : (32'sd0 - s7_d);
      s7_neg_r <= s7_d[31];
      s7_f10_r <= s6_cf_r * c10_r;
      s7_f11_r <= s6_cf_r * c11_r;
      s7_rt_r  <= s6_rt_r;
      s7_up_r  <= s6_up_r;
    end
    // Split sensitivity product and pressure offset removal
    if (en[8]) begin
      s8_x24_r  <= (s7_x23_r >>> 11) * k7_r;
      s8_x25m_r <= (s7_x23_r & 32'sh7FF) * k7_r;
      s8_neg_r  <= s7_neg_r;
      s8_pp1_r  <= ((s7_up_r - RawOffset) - s7_x13_r) >>> 3;
      s8_f10_r  <= s7_f10_r >>> 17;
      s8_f11_r  <= s7_f11_r >>> 15;
      s8_rt_r   <= s7_rt_r;
    end
    // Sensitivity
    if (en[9]) begin
      s9_x26_r <= (s9_sum >>> 11) + k7_r;
      s9_pp1_r <= s8_pp1_r;
      s9_f10_r <= s8_f10_r;
      s9_f11_r <= s8_f11_r;
      s9_rt_r  <= s8_rt_r;
    end
    // Split pressure scaling product
    if (en[10]) begin
      s10_pp2_r  <= (s9_x26_r >>> 11) * s9_pp1_r;
      s10_pp3m_r <= (s9_x26_r & 32'sh7FF) * s9_pp1_r;
      s10_f10_r  <= s9_f10_r;
      s10_f11_r  <= s9_f11_r;
      s10_rt_r   <= s9_rt_r;
    end
    // Intermediate pressure
    if (en[11]) begin
      s11_pp4_r <= (s10_pp2_r + s12_pp3) >>> 10;
      s11_f10_r <= s10_f10_r;
      s11_f11_r <= s10_f11_r;
      s11_rt_r  <= s10_rt_r;
    end
    // Nonlinearity products
    if (en[12]) begin
      s12_y31_r <= s11_f10_r * s11_pp4_r;
      s12_y32_r <= s11_f11_r * s11_pp4_r;
      s12_pp4_r <= s11_pp4_r;
      s12_rt_r  <= s11_rt_r;
    end
    // Quadratic nonlinearity term
    if (en[13]) begin
      s13_x31_r <= s12_y31_r >>> 2;
      s13_x32_r <= (s12_y32_r >>> 18) * s12_pp4_r;
      s13_pp4_r <= s12_pp4_r;
      s13_rt_r  <= s12_rt_r;
    end
    // Output register
    if (en[14]) begin
      s14_rp_r <= ((s13_x31_r + s13_x32_r) >>> 15) + s13_pp4_r + PressBase;
      s14_rt_r <= s13_rt_r;
    end
  end

  assign out_data.pressure_pa = s14_rp_r;
  assign out_data.temp_centi  = s14_rt_r;

  // Checks on pipeline occupancy
  logic in_take, out_take;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled while a stage is empty");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !out_take) |=> ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("accepted request lost in pipeline");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_take && out_take) |=> ($countones(v_r) + 1 == $past($countones(v_r))))
    else $error("delivered result not removed from pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

FILE: tb/bpc_checker.sv
// Checker for the barometric compensation block: predicts each result from
// accepted requests and compares it with the result channel. Depends on bpc_pkg.
module bpc_checker
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  bpc_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  bpc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [15:0] cal_word [10];
  logic [7:0]  formula_sel;
  bpc_out_t    compensated_q [$];

  // Arithmetic right shift on a 32-bit word.
  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    sra = $signed(x) >>> n;
  endfunction

  // Compensate one raw pressure and temperature pair.
  function automatic bpc_out_t compensate(input bpc_in_t req);
    logic [31:0] r [10];
    logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
    logic [31:0] k1, k5, k4, k8, k7, up, ut, dt, x01, x02, x03, rt, dt2;
    logic [31:0] x11, x12, x13, x21, x22, x23, x24, x25, x26;
    logic [31:0] pp1, pp2, pp3, pp4, cf, x31, x32, rp;
    logic        rev2;
    bpc_out_t    res;
    for (int i = 0; i < 10; i++) r[i] = {16'd0, cal_word[i]};
    rev2 = (formula_sel[7:4] == 4'h1) || (formula_sel[3:0] == 4'h1);
    c0  = r[0] >> 4;
    c1  = ((r[1] & 32'hFF00) >> 5) | (r[2] & 32'd7);
    c2  = ((r[1] & 32'hFF) << 1) | (r[4] & 32'd1);
    c3  = r[2] >> 3;
    c5  = r[4] >> 1;
    c6  = r[5] >> 3;
    c8  = r[7] >> 3;
    c9  = r[8] >> 2;
    c10 = ((r[9] & 32'hFF00) >> 6) | (r[8] & 32'd3);
    c11 = r[9] & 32'hFF;
    if (rev2) begin
      c4  = (r[3] << 2) | (r[0] & 32'd3);
      c7  = (r[6] << 3) | (r[5] & 32'd7);
      c12 = ((r[0] & 32'hC) << 1) | (r[7] & 32'd7);
      k1 = 32'd4459; k5 = 32'd4443; k4 = 32'd120586; k8 = 32'd7180; k7 = 32'd166426;
    end else begin
      c4  = (r[3] << 1) | (r[5] & 32'd1);
      c7  = (r[6] << 2) | ((r[0] >> 2) & 32'd3);
      c12 = ((r[5] & 32'd6) << 2) | (r[7] & 32'd7);
      k1 = 32'd4418; k5 = 32'd0; k4 = 32'd211288; k8 = 32'd7209; k7 = 32'd285594;
    end
    up = {8'd0, req.raw_pressure};
    ut = {8'd0, req.raw_temperature};
    // Temperature polynomial.
    dt  = sra(ut - 32'd8388608, 4) + (c0 << 4);
    x01 = sra((c1 + k1) * dt, 1);
    x02 = sra(sra((c2 - 32'd256) * dt, 14) * dt, 4);
    x03 = sra(sra(c3 * dt, 18) * dt, 18) * dt;
    rt  = sra((32'd2500 << 15) - x01 - x02 - x03, 15);
    dt2 = sra(x01 + x02 + x03, 12);
    // Offset and sensitivity terms.
    x11 = (c5 - k5) * dt2;
    x12 = sra(sra(c6 * dt2, 16) * dt2, 2);
    x13 = sra(x11 + x12, 10) + ((c4 + k4) << 4);
    x21 = sra((c8 + k8) * dt2, 10);
    x22 = sra(sra(c9 * dt2, 17) * dt2, 12);
    x23 = ($signed(x22) >= $signed(x21)) ? x22 - x21 : x21 - x22;
    x24 = sra(x23, 11) * (c7 + k7);
    x25 = sra((x23 & 32'h7FF) * (c7 + k7), 11);
    if (((x22 - x21) & 32'h8000_0000) != 0) x26 = sra(32'd0 - x24 - x25, 11) + c7 + k7;
    else x26 = sra(x24 + x25, 11) + c7 + k7;
    // Pressure polynomial.
    pp1 = sra((up - 32'd8388608) - x13, 3);
    pp2 = sra(x26, 11) * pp1;
    pp3 = sra((x26 & 32'h7FF) * pp1, 11);
    pp4 = sra(pp2 + pp3, 10);
    cf  = sra(32'd2097152 + c12 * dt2, 3);
    x31 = sra(sra(cf * c10, 17) * pp4, 2);
    x32 = sra(sra(cf * c11, 15) * pp4, 18) * pp4;
    rp  = sra(x31 + x32, 15) + pp4 + 32'd99880;
    res.pressure_pa = rp;
    res.temp_centi  = rt;
    return res;
  endfunction

  // Track configuration, queue predictions and compare results.
  always @(posedge clk) begin
    bpc_out_t exp_res;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < 10; i++) cal_word[i] <= 16'd0;
      formula_sel <= 8'd1;
      compensated_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (bpc_reg_t'(cfg_index))
          REG_CAL_LOW: begin
            for (int i = 0; i < 4; i++) cal_word[i] <= cfg_wdata[16*i +: 16];
          end
          REG_CAL_MID: begin
            for (int i = 0; i < 4; i++) cal_word[4+i] <= cfg_wdata[16*i +: 16];
          end
          REG_CAL_HIGH: begin
            cal_word[8] <= cfg_wdata[15:0];
            cal_word[9] <= cfg_wdata[31:16];
          end
          REG_FORMULA: begin
            formula_sel <= cfg_wdata[7:0];
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) compensated_q.push_back(compensate(in_data));
      if (out_valid && !out_stall) begin
        if (compensated_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h", $time, out_data);
          errs = errs + 1;
        end else begin
          exp_res = compensated_q.pop_front();
          if (exp_res.pressure_pa !== out_data.pressure_pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time,
                     exp_res.pressure_pa, out_data.pressure_pa);
            errs = errs + 1;
          end
          if (exp_res.temp_centi !== out_data.temp_centi) begin
            $display("%0t: temp_centi expected %0d actual %0d", $time,
                     exp_res.temp_centi, out_data.temp_centi);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= compensated_q.size();
    end
  end

endmodule

FILE: tb/tb_baro_pressure_temp_compensation.sv
// Testbench top for baro_pressure_temp_compensation: drives requests and
// configuration, and gives the verdict. Depends on bpc_pkg and bpc_checker.
module tb_baro_pressure_temp_compensation;
  import bpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bpc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bpc_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_wdata = 64'd0;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  always #4 clk = ~clk;

  baro_pressure_temp_compensation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bpc_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Send one request, with a random gap first. The valid stays high after the
  // request is taken so that back-to-back requests need no gap; callers that
  // stop sending drop it themselves.
  task automatic send_sample(input logic [23:0] press, input logic [23:0] temp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{raw_pressure: press, raw_temperature: temp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Let the pipeline drain before touching configuration.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input bpc_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_cal(input logic [63:0] lo, input logic [63:0] mid,
                          input logic [31:0] hi, input logic [7:0] fsel);
    drain();
    write_reg(REG_CAL_LOW, lo);
    write_reg(REG_CAL_MID, mid);
    write_reg(REG_CAL_HIGH, {32'd0, hi});
    write_reg(REG_FORMULA, {56'd0, fsel});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a sample: mostly random, sometimes extremes.
  function automatic logic [23:0] pick24();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'h800000 + 24'($urandom_range(4095)) - 24'd2048;
      default: return 24'($urandom());
    endcase
  endfunction

  // Formula codes covering both revisions and unknown codes.
  function automatic logic [7:0] pick_formula();
    case ($urandom_range(5))
      0: return 8'h01;
      1: return 8'h10;
      2: return {4'h1, 4'($urandom())};
      3: return {4'($urandom()), 4'h1};
      4: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset calibration, then extremes on both formulas.
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    load_cal('1, '1, '1, 8'h00);
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h800000, 24'h7FFFFF);
    load_cal('1, '1, '1, 8'h10);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    send_sample(24'h123456, 24'h654321);
    load_cal(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 8'hFF);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'hAAAAAA, 24'h555555);
    load_cal(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 8'h21);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'hFFFFFF, 24'h000001);

    // Random phases with differing idle mixes.
    for (int ph = 0; ph < 12; ph++) begin
      load_cal(rand64(), rand64(), $urandom(), pick_formula());
      if (ph < 4) begin
        send_idle_pct = 16; recv_idle_pct = 70;
      end else if (ph < 8) begin
        send_idle_pct = 70; recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 108; n++) begin
        // Hold off mid-phase until every result is back.
        if (n == 54) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
        send_sample(pick24(), pick24());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
